// ===== design/byte_buffer_bit_reader_assert.svh =====
// assertion macros for the byte buffer bit reader checker
// expects signals named clk and rst in the scope that uses them
`ifndef BYTE_BUFFER_BIT_READER_ASSERT_SVH
`define BYTE_BUFFER_BIT_READER_ASSERT_SVH

// checked on every rising edge outside reset
`define BBR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every rising edge, reset included
`define BBR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/bbr_pkg.sv =====
// shared types, constants and helpers of the byte buffer bit reader
// no dependencies
package bbr_pkg;

  localparam int STORE_DEPTH    = 4096;
  localparam int MAX_READ_BITS  = 32;
  localparam int MAX_READ_BYTES = 4;

  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int LEN_W  = 13;
  localparam int POS_W  = LEN_W + 3;
  localparam int NB_W   = 6;
  localparam int VAL_W  = 32;

  // fetch window: enough bytes for the widest bit read at any bit offset
  localparam int WIN_RAW   = (MAX_READ_BITS + 14) / 8;
  localparam int WIN_BYTES = (WIN_RAW > MAX_READ_BYTES) ? WIN_RAW : MAX_READ_BYTES;
  localparam int WIN_W     = 8 * WIN_BYTES;
  localparam int CNT_W     = $clog2(WIN_BYTES + 1);
  localparam int SH_W      = $clog2(WIN_W + 1);

  localparam logic [31:0] DEPTH_W32 = 32'(STORE_DEPTH);

  localparam logic [2:0] KIND_WRITE     = 3'd0;
  localparam logic [2:0] KIND_RESTART   = 3'd1;
  localparam logic [2:0] KIND_READ_LSB  = 3'd2;
  localparam logic [2:0] KIND_READ_MSB  = 3'd3;
  localparam logic [2:0] KIND_READ_CODE = 3'd4;
  localparam logic [2:0] KIND_READ_BYTES = 3'd5;
  localparam logic [2:0] KIND_ALIGN     = 3'd6;

  typedef struct packed {
    logic [2:0]      kind;
    logic [NB_W-1:0] count;
    logic [7:0]      data_byte;
  } bbr_req_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             overrun;
    logic [LEN_W-1:0] byte_offset;
    logic [2:0]       bit_offset;
  } bbr_res_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
  } bbr_mem_req_t;

  function automatic logic [7:0] rev8(input logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = b[7-i];
    end
    return r;
  endfunction

endpackage

// ===== design/bbr_store.sv =====
// byte store: single port, registered read data
// depends on bbr_pkg
module bbr_store import bbr_pkg::*; (
  input  logic         clk,
  input  bbr_mem_req_t req,
  output logic [7:0]   rd_data
);

  logic [7:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[req.addr];
  end

endmodule

// ===== design/bbr_core.sv =====
// sequencer and shared add/compare and shift unit of the bit reader
// depends on bbr_pkg; drives the byte store
module bbr_core import bbr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [LEN_W-1:0] stream_length,
  input  logic             req_valid,
  output logic             req_ready,
  input  bbr_req_t         req,
  output bbr_mem_req_t     mem_req,
  input  logic [7:0]       mem_rd_data,
  output logic             res_valid,
  input  logic             res_ready,
  output bbr_res_t         res
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_FETCH  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;
  localparam logic [2:0] S_WRITE  = 3'd5;

  localparam logic [1:0] MODE_LSB  = 2'd0;
  localparam logic [1:0] MODE_MSB  = 2'd1;
  localparam logic [1:0] MODE_CODE = 2'd2;

  logic [2:0]       state;
  bbr_req_t         cur;
  logic [LEN_W-1:0] bp;
  logic [2:0]       bitp;
  logic [LEN_W-1:0] base;
  logic [2:0]       sh;
  logic [NB_W-1:0]  nbits;
  logic [1:0]       mode;
  logic             far;
  logic             ovr;
  logic [VAL_W-1:0] value;
  logic [WIN_W-1:0] acc;
  logic [CNT_W-1:0] fcnt;

  logic [LEN_W-1:0] len;
  logic [NB_W-1:0]  n_bits_sat;
  logic [NB_W-1:0]  n_bytes_sat;
  logic [LEN_W:0]   step_up;
  logic [LEN_W-1:0] start;
  logic [POS_W:0]   newpos;
  logic [POS_W:0]   limit;
  logic [7:0]       in_byte;
  logic [WIN_W-1:0] acc_next;
  logic [SH_W-1:0]  amt;
  logic [WIN_W-1:0] shifted;
  logic [VAL_W:0]   mask;
  logic             wr_ok;

  always_comb begin
    len = (32'(stream_length) > DEPTH_W32) ? DEPTH_W32[LEN_W-1:0] : stream_length;
    n_bits_sat  = (cur.count > NB_W'(MAX_READ_BITS)) ? NB_W'(MAX_READ_BITS) : cur.count;
    n_bytes_sat = (cur.count > NB_W'(MAX_READ_BYTES)) ? NB_W'(MAX_READ_BYTES) : cur.count;
    step_up = {1'b0, bp} + (LEN_W+1)'(bitp != 3'd0);
    start   = (step_up > {1'b0, len}) ? len : step_up[LEN_W-1:0];
    wr_ok   = bp < len;
    // shared adder and compare: end position of the access against the stream end
    newpos  = {1'b0, base, sh} + (POS_W+1)'(nbits);
    limit   = {1'b0, len, 3'b000};
  end

  // shift register assembling the fetch window
  always_comb begin
    in_byte = (mode == MODE_CODE) ? rev8(mem_rd_data) : mem_rd_data;
    if (mode == MODE_MSB) begin
      acc_next = {acc[WIN_W-9:0], in_byte};
    end else begin
      acc_next = {in_byte, acc[WIN_W-1:8]};
    end
  end

  // shared barrel shifter and field mask
  always_comb begin
    if (mode == MODE_MSB) begin
      amt = SH_W'(WIN_W) - SH_W'(sh) - SH_W'(nbits);
    end else begin
      amt = SH_W'(sh);
    end
    shifted = acc >> amt;
    mask    = ((VAL_W+1)'(1) << nbits) - (VAL_W+1)'(1);
  end

  always_comb begin
    mem_req.wr_en = (state == S_DECODE) && (cur.kind == KIND_WRITE) && wr_ok;
    mem_req.wdata = cur.data_byte;
    if (state == S_DECODE) begin
      mem_req.addr = ADDR_W'(bp);
    end else begin
      mem_req.addr = ADDR_W'(base) + ADDR_W'(fcnt);
    end
  end

  assign req_ready       = (state == S_IDLE);
  assign res_valid       = (state == S_WRITE);
  assign res.value       = value;
  assign res.overrun     = ovr;
  assign res.byte_offset = bp;
  assign res.bit_offset  = bitp;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      bp    <= '0;
      bitp  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            cur   <= req;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          value <= '0;
          ovr   <= 1'b0;
          state <= S_WRITE;
          case (cur.kind)
            KIND_WRITE: begin
              if (wr_ok) begin
                bp <= bp + LEN_W'(1);
              end else begin
                ovr <= 1'b1;
              end
            end
            KIND_RESTART: begin
              bp   <= '0;
              bitp <= '0;
            end
            KIND_READ_LSB, KIND_READ_MSB, KIND_READ_CODE: begin
              base  <= bp;
              sh    <= bitp;
              nbits <= n_bits_sat;
              far   <= 1'b0;
              if (cur.kind == KIND_READ_MSB) begin
                mode <= MODE_MSB;
              end else if (cur.kind == KIND_READ_CODE) begin
                mode <= MODE_CODE;
              end else begin
                mode <= MODE_LSB;
              end
              state <= S_CHECK;
            end
            KIND_READ_BYTES: begin
              base  <= start;
              sh    <= '0;
              nbits <= NB_W'({n_bytes_sat, 3'b000});
              far   <= bp > len;
              mode  <= MODE_MSB;
              state <= S_CHECK;
            end
            KIND_ALIGN: begin
              if (bitp != 3'd0) begin
                bp   <= start;
                bitp <= '0;
              end
            end
            default: begin
            end
          endcase
        end
        S_CHECK: begin
          fcnt <= '0;
          if (newpos > limit || far) begin
            // overrun: all ones, park at the stream end
            ovr   <= 1'b1;
            value <= '1;
            bp    <= len;
            bitp  <= '0;
            state <= S_WRITE;
          end else begin
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          if (fcnt != '0) begin
            acc <= acc_next;
          end
          fcnt <= fcnt + CNT_W'(1);
          if (fcnt == CNT_W'(WIN_BYTES)) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          value <= shifted[VAL_W-1:0] & mask[VAL_W-1:0];
          bp    <= LEN_W'(newpos >> 3);
          bitp  <= newpos[2:0];
          state <= S_WRITE;
        end
        S_WRITE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/byte_buffer_bit_reader.sv =====
// byte buffer bit reader, top level: stream ports, length register, result register
// depends on bbr_pkg, bbr_store, bbr_core
//
//   channel  | handshake              | payload
//   ---------+------------------------+-------------------------------------------
//   request  | s_tvalid / s_tready    | s_tuser kind, s_tdata count and data byte
//   result   | m_tvalid / m_tready    | m_tdata value and position, m_tuser overrun
//   config   | cfg_valid / cfg_ready  | cfg_data stream length
//
// writes, restarts and aligns pass through decode and handoff from one accepted beat
// to the next, reads that overrun through decode, bound check and handoff; a read in
// range through decode, bound check, a fetch of a five byte window through the
// single store port (one byte per cycle, registered read data), the window shift and
// mask, and handoff. the result register lets a new request in while the last result
// waits. synchronous reset clears the position and the length; the byte store is not
// cleared and holds garbage until written. cfg_ready is always high.
module byte_buffer_bit_reader import bbr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // count [5:0], data_byte [13:6], zero [15:14]
  input  logic [2:0]  s_tuser,   // kind [2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // value [31:0], byte_offset [44:32], bit_offset [47:45]
  output logic [0:0]  m_tuser,   // overrun [0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_data   // stream_length
);

  logic [LEN_W-1:0] stream_length;
  bbr_req_t         req;
  bbr_res_t         res;
  bbr_mem_req_t     mem_req;
  logic [7:0]       mem_rd_data;
  logic             res_valid;
  logic             res_ready;

  // length register, writable any time the block is idle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stream_length <= '0;
    end else if (cfg_valid) begin
      stream_length <= cfg_data;
    end
  end

  // unpack the request beat
  assign req.kind      = s_tuser;
  assign req.count     = s_tdata[5:0];
  assign req.data_byte = s_tdata[13:6];

  bbr_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (mem_rd_data)
  );

  bbr_core u_core (
    .clk           (clk),
    .rst           (rst),
    .stream_length (stream_length),
    .req_valid     (s_tvalid),
    .req_ready     (s_tready),
    .req           (req),
    .mem_req       (mem_req),
    .mem_rd_data   (mem_rd_data),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res)
  );

  // result register: loads when empty or being drained this cycle
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= {res.bit_offset, res.byte_offset, res.value};
      m_tuser <= res.overrun;
    end
  end

endmodule

// ===== design/bbr_checker.sv =====
// port level checks for the byte buffer bit reader, bound to the top level
// depends on bbr_pkg and byte_buffer_bit_reader_assert.svh
`include "byte_buffer_bit_reader_assert.svh"

module bbr_checker import bbr_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [15:0] s_tdata,
  input logic [2:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic [0:0]  m_tuser,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [12:0] cfg_data
);

  // a stalled result beat holds
  `BBR_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")

  // one request at a time: busy right after an accepted beat
  `BBR_ASSERT(a_one_at_a_time, s_tvalid && s_tready |=> !s_tready, "request taken while busy")

  // an overrun gives all ones at a byte boundary, or zero for a refused write
  `BBR_ASSERT(a_overrun_value, m_tvalid && m_tuser[0] |-> (m_tdata[31:0] == 32'hFFFFFFFF && m_tdata[47:45] == 3'd0) || m_tdata[31:0] == 32'd0, "bad overrun result")

  // the byte position never passes the store
  `BBR_ASSERT(a_pos_bound, m_tvalid |-> 32'(m_tdata[44:32]) <= DEPTH_W32, "byte offset past store")

  // reset empties the result register
  `BBR_ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> !m_tvalid, "result valid after reset")

endmodule

bind byte_buffer_bit_reader bbr_checker u_bbr_checker (.*);

// ===== verif/bbr_stream_checker.sv =====
// checker for the byte buffer bit reader: watches request, config and result beats,
// predicts each result from a shadow of the byte store and position, and counts mismatches
// depends on bbr_pkg
`timescale 1ns / 1ps

module bbr_stream_checker import bbr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,   // count [5:0], data_byte [13:6], zero [15:14]
  input  logic [2:0]  s_tuser,   // kind [2:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,   // value [31:0], byte_offset [44:32], bit_offset [47:45]
  input  logic [0:0]  m_tuser,   // overrun [0]
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [12:0] cfg_data,  // stream_length
  output int          error_count,
  output int          pending
);

  logic [7:0]  shadow_bytes [STORE_DEPTH];
  int unsigned byte_ptr;
  int unsigned bit_ptr;
  int unsigned stream_len;

  bbr_res_t expected_results [$];
  int       mismatches = 0;
  int       results_seen = 0;
  int       owed = 0;

  assign error_count = mismatches;
  assign pending     = owed;

  // advance the shadow position for one request and build the result it should give
  task automatic predict_step(input bbr_req_t rq, output bbr_res_t res);
    int unsigned len;
    int unsigned nbits;
    int unsigned pos;
    int unsigned start;
    logic [7:0]  cur;
    logic [31:0] acc;
    logic        ovr;
    len = (stream_len > STORE_DEPTH) ? STORE_DEPTH : stream_len;
    acc = '0;
    ovr = 1'b0;
    case (rq.kind)
      KIND_WRITE: begin
        // a write past the end stores nothing and keeps the position
        if (byte_ptr >= len) begin
          ovr = 1'b1;
        end else begin
          shadow_bytes[byte_ptr] = rq.data_byte;
          byte_ptr++;
        end
      end
      KIND_RESTART: begin
        byte_ptr = 0;
        bit_ptr  = 0;
      end
      KIND_READ_LSB, KIND_READ_MSB, KIND_READ_CODE: begin
        nbits = (rq.count > MAX_READ_BITS) ? MAX_READ_BITS : rq.count;
        pos   = byte_ptr * 8 + bit_ptr;
        if (pos + nbits > len * 8) begin
          ovr = 1'b1;
        end else begin
          for (int i = 0; i < nbits; i++) begin
            cur = shadow_bytes[pos / 8];
            if (rq.kind == KIND_READ_LSB) begin
              acc[i] = cur[pos % 8];
            end else if (rq.kind == KIND_READ_MSB) begin
              acc = {acc[30:0], cur[7 - (pos % 8)]};
            end else begin
              // code path: msb-first within the byte, packed lsb-first
              acc[i] = cur[7 - (pos % 8)];
            end
            pos++;
          end
          byte_ptr = pos / 8;
          bit_ptr  = pos % 8;
        end
      end
      KIND_READ_BYTES: begin
        nbits = (rq.count > MAX_READ_BYTES) ? MAX_READ_BYTES : rq.count;
        start = byte_ptr + ((bit_ptr != 0) ? 1 : 0);
        if (start > len) start = len;
        if (start + nbits > len || byte_ptr > len) begin
          ovr = 1'b1;
        end else begin
          for (int i = 0; i < nbits; i++) begin
            acc = {acc[23:0], shadow_bytes[start + i]};
          end
          byte_ptr = start + nbits;
          bit_ptr  = 0;
        end
      end
      KIND_ALIGN: begin
        // never moves past the stream end
        if (bit_ptr != 0) begin
          byte_ptr = (byte_ptr + 1 > len) ? len : byte_ptr + 1;
          bit_ptr  = 0;
        end
      end
      default: begin
      end
    endcase
    if (ovr && rq.kind != KIND_WRITE) begin
      acc      = '1;
      byte_ptr = len;
      bit_ptr  = 0;
    end
    res.value       = acc;
    res.overrun     = ovr;
    res.byte_offset = LEN_W'(byte_ptr);
    res.bit_offset  = 3'(bit_ptr);
  endtask

  always @(posedge clk) begin : monitor
    bbr_req_t rq;
    bbr_res_t want;
    bbr_res_t got;
    if (rst) begin
      byte_ptr   = 0;
      bit_ptr    = 0;
      stream_len = 0;
      expected_results.delete();
    end else begin
      // result side first: the oldest expectation belongs to this beat
      if (m_tvalid && m_tready) begin
        got.value       = m_tdata[31:0];
        got.byte_offset = m_tdata[44:32];
        got.bit_offset  = m_tdata[47:45];
        got.overrun     = m_tuser[0];
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result beat %0d with nothing expected: value %h overrun %b byte %0d bit %0d",
                     results_seen, got.value, got.overrun, got.byte_offset, got.bit_offset);
          end
        end else begin
          want = expected_results.pop_front();
          if (got.value !== want.value || got.overrun !== want.overrun ||
              got.byte_offset !== want.byte_offset || got.bit_offset !== want.bit_offset) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result beat %0d mismatch: expected value %h overrun %b byte %0d bit %0d",
                       results_seen, want.value, want.overrun, want.byte_offset,
                       want.bit_offset);
              $display("  got value %h overrun %b byte %0d bit %0d",
                       got.value, got.overrun, got.byte_offset, got.bit_offset);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        stream_len = cfg_data;
      end
      if (s_tvalid && s_tready) begin
        rq.kind      = s_tuser;
        rq.count     = s_tdata[5:0];
        rq.data_byte = s_tdata[13:6];
        predict_step(rq, want);
        expected_results.push_back(want);
      end
    end
    owed = expected_results.size();
  end

endmodule

// ===== verif/testbench.sv =====
// top of the byte buffer bit reader testbench: clock, reset, request and config stimulus,
// random result backpressure, watchdog and verdict
// depends on bbr_pkg, byte_buffer_bit_reader and bbr_stream_checker
`timescale 1ns / 1ps

module testbench;
  import bbr_pkg::*;

  localparam logic [2:0] KIND_UNUSED = 3'd7;
  localparam int QUIET_LIMIT     = 2000;
  localparam int SETTLE_CYCLES   = 24;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int FILL_BYTES      = 256;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic [2:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [12:0] cfg_data;

  int error_count;
  int pending;
  int quiet_cycles = 0;
  bit no_gaps = 1'b0;

  byte_buffer_bit_reader i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  bbr_stream_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .error_count (error_count),
    .pending     (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // result backpressure: about a third of cycles stalled unless in a gap-free stretch
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_tready = no_gaps ? 1'b1 : ($urandom_range(0, 99) >= 33);
    end
  end

  // ends the run when no beat moves on any channel for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("byte_buffer_bit_reader verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one request beat, with random source gaps before it
  task automatic send_request(input logic [2:0] kind, input logic [5:0] count,
                              input logic [7:0] data_byte);
    @(negedge clk);
    while (!no_gaps && $urandom_range(0, 99) < 33) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = kind;
    s_tdata  = {2'b00, data_byte, count};
    do @(posedge clk); while (!s_tready);
  endtask

  // stop sending and wait for every owed result beat
  task automatic drain_results();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // only called with the request side idle and nothing owed
  task automatic set_stream_length(input logic [12:0] len);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = len;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin : stimulus
    int unsigned roll;
    logic [2:0]  kind;
    logic [5:0]  count;
    logic [12:0] len;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = KIND_WRITE;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty stream: reads overrun, zero-size reads pass, a write past the end is refused
    set_stream_length(13'd0);
    send_request(KIND_READ_LSB, 6'd1, 8'h00);
    send_request(KIND_READ_MSB, 6'd0, 8'h00);
    send_request(KIND_READ_BYTES, 6'd0, 8'h00);
    send_request(KIND_WRITE, 6'd0, 8'hA5);
    send_request(KIND_ALIGN, 6'd0, 8'h00);
    send_request(KIND_UNUSED, 6'd63, 8'hFF);
    drain_results();

    // fill the head of the store so no later read touches an unwritten byte,
    // then one write past the end
    set_stream_length(13'(FILL_BYTES));
    send_request(KIND_RESTART, 6'd0, 8'h00);
    repeat (FILL_BYTES + 1) begin
      send_request(KIND_WRITE, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)));
    end
    drain_results();

    // short stream: each read flavor, saturated counts, alignment, overrun at the end
    set_stream_length(13'd16);
    send_request(KIND_RESTART, 6'd0, 8'h00);
    send_request(KIND_READ_LSB, 6'd1, 8'h00);
    send_request(KIND_READ_MSB, 6'd7, 8'h00);
    send_request(KIND_READ_CODE, 6'd9, 8'h00);
    send_request(KIND_READ_LSB, 6'd32, 8'h00);
    send_request(KIND_ALIGN, 6'd0, 8'h00);
    send_request(KIND_ALIGN, 6'd0, 8'h00);
    send_request(KIND_READ_MSB, 6'd63, 8'h00);
    send_request(KIND_READ_CODE, 6'd3, 8'h00);
    send_request(KIND_READ_BYTES, 6'd2, 8'h00);
    send_request(KIND_READ_BYTES, 6'd9, 8'h00);
    send_request(KIND_READ_LSB, 6'd0, 8'h00);
    send_request(KIND_WRITE, 6'd0, 8'h3C);
    send_request(KIND_RESTART, 6'd0, 8'h00);
    send_request(KIND_WRITE, 6'd0, 8'h00);
    send_request(KIND_WRITE, 6'd0, 8'hFF);
    send_request(KIND_READ_CODE, 6'd5, 8'h00);
    send_request(KIND_READ_LSB, 6'd33, 8'h00);
    drain_results();

    // shrink the stream under a mid-byte position: align must stop at the end
    set_stream_length(13'd5);
    send_request(KIND_ALIGN, 6'd0, 8'h00);
    drain_results();

    // random phases, mostly reads over the filled head, each at its own length
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       len = 13'd1;
        1:       len = 13'd4096;
        2:       len = 13'($urandom_range(5, 40));
        3:       len = 13'd8191;
        4:       len = 13'd2;
        5:       len = 13'd4095;
        6:       len = 13'($urandom_range(100, 300));
        default: len = 13'($urandom_range(1, 12));
      endcase
      no_gaps = (p == 1 || p == 2);
      set_stream_length(len);
      // a long stream always restarts: one item moves at most five bytes, so a phase
      // stays inside the filled head; a short one may keep a position past its end
      if (len > 13'(FILL_BYTES) || $urandom_range(0, 9) < 7) begin
        send_request(KIND_RESTART, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)));
      end
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < 14)      kind = KIND_WRITE;
        else if (roll < 22) kind = KIND_RESTART;
        else if (roll < 38) kind = KIND_READ_LSB;
        else if (roll < 54) kind = KIND_READ_MSB;
        else if (roll < 68) kind = KIND_READ_CODE;
        else if (roll < 84) kind = KIND_READ_BYTES;
        else if (roll < 96) kind = KIND_ALIGN;
        else                kind = KIND_UNUSED;
        roll = $urandom_range(0, 9);
        if (kind == KIND_READ_LSB || kind == KIND_READ_MSB || kind == KIND_READ_CODE) begin
          // mostly legal bit counts, some zero, some above the read width
          if (roll == 0)      count = 6'd0;
          else if (roll == 1) count = 6'($urandom_range(33, 63));
          else                count = 6'($urandom_range(1, 32));
        end else if (kind == KIND_READ_BYTES) begin
          count = (roll < 8) ? 6'($urandom_range(0, 4)) : 6'($urandom_range(5, 63));
        end else begin
          count = 6'($urandom_range(0, 63));
        end
        send_request(kind, count, 8'($urandom_range(0, 255)));
      end
      drain_results();
    end
    no_gaps = 1'b0;

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (error_count == 0 && pending == 0) begin
      $display("byte_buffer_bit_reader verification clean");
    end else begin
      $display("byte_buffer_bit_reader verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/bbr_pkg.sv
design/bbr_store.sv
design/bbr_core.sv
design/byte_buffer_bit_reader.sv
design/bbr_checker.sv
verif/bbr_stream_checker.sv
verif/testbench.sv
